// ===== hdl/phh_pkg.sv =====
// Shared types, constants and register map of the pixel hit histogram unit.
`default_nettype none
package phh_pkg;

    localparam int DEF_MAX_COLS   = 8;
    localparam int DEF_MAX_ROWS   = 8;
    localparam int DEF_COUNT_BITS = 24;

    localparam int FIFO_DEPTH = 4;
    localparam int OFF_BITS   = 17;
    localparam int CFG_IDX_BITS = 4;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COLUMNS   = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_ROWS      = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAP_MODE      = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_WIDTH  = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_HEIGHT = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_WIDTH   = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_HEIGHT  = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAP_THICKNESS = 4'd7;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_HIT   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [3:0]  num_columns;
        logic [3:0]  num_rows;
        logic        gap_mode;
        logic [15:0] active_width;
        logic [15:0] active_height;
        logic [15:0] pixel_width;
        logic [15:0] pixel_height;
        logic [15:0] gap_thickness;
    } cfg_t;

    typedef struct packed {
        cmd_t                kind;
        logic                neg_x;
        logic                neg_y;
        logic [OFF_BITS-1:0] off_x;
        logic [OFF_BITS-1:0] off_y;
    } item_t;

    typedef struct packed {
        logic        hit_valid;
        logic [2:0]  hit_col;
        logic [2:0]  hit_row;
        logic [16:0] centroid_x;
        logic [16:0] centroid_y;
        logic        centroid_ok;
    } res_t;

endpackage
`default_nettype wire

// ===== hdl/pixel_hit_histogram_centroid_unit.sv =====
// Top level of the pixel hit histogram and centroid unit.
//
//   channel  direction  handshake              payload
//   input    in         push / full            command, pos_x, pos_y
//   result   out        empty / pop            hit_valid, hit_col, hit_row,
//                                              centroid_x, centroid_y, centroid_ok
//   config   in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Items are handled one at a time by the back end; a four-entry queue behind
// the input lets the source run ahead. An add hit runs the 17-step axis dividers
// and a store read-modify-write, skipped on a miss (rejected hits skip both);
// clear and unused codes go straight to the result (valid bits drop at once);
// a query walks the store, then runs the 17-step centroid dividers.
// Reset clears the histogram through its valid bits and restores the register
// defaults; no clearing pass is needed. A result waiting for pop holds the back
// end only when the next result is ready.
`default_nettype none
module pixel_hit_histogram_centroid_unit
    import phh_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic [1:0]               command,
    input  wire logic [15:0]              pos_x,
    input  wire logic [15:0]              pos_y,
    output logic                          empty,
    input  wire logic                     pop,
    output logic                          hit_valid,
    output logic [2:0]                    hit_col,
    output logic [2:0]                    hit_row,
    output logic [16:0]                   centroid_x,
    output logic [16:0]                   centroid_y,
    output logic                          centroid_ok,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);
    cfg_t  cfg_reg, cfg_next;
    item_t item;
    logic  item_valid, item_pop;
    res_t  res;

    // registers take every write; the port never stalls
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_NUM_COLUMNS:   cfg_next.num_columns   = cfg_data[3:0];
                REG_NUM_ROWS:      cfg_next.num_rows      = cfg_data[3:0];
                REG_GAP_MODE:      cfg_next.gap_mode      = cfg_data[0];
                REG_ACTIVE_WIDTH:  cfg_next.active_width  = cfg_data;
                REG_ACTIVE_HEIGHT: cfg_next.active_height = cfg_data;
                REG_PIXEL_WIDTH:   cfg_next.pixel_width   = cfg_data;
                REG_PIXEL_HEIGHT:  cfg_next.pixel_height  = cfg_data;
                REG_GAP_THICKNESS: cfg_next.gap_thickness = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_columns   <= 4'd8;
            cfg_reg.num_rows      <= 4'd8;
            cfg_reg.gap_mode      <= 1'b0;
            cfg_reg.active_width  <= 16'd3200;
            cfg_reg.active_height <= 16'd3200;
            cfg_reg.pixel_width   <= 16'd400;
            cfg_reg.pixel_height  <= 16'd400;
            cfg_reg.gap_thickness <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // decode and queue incoming items
    phh_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .command(command), .pos_x(pos_x), .pos_y(pos_y),
        .active_width(cfg_reg.active_width), .active_height(cfg_reg.active_height),
        .item_valid(item_valid), .item(item), .item_pop(item_pop)
    );

    // map, count, walk the store and hold the result for transfer
    phh_back #(
        .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .item_valid(item_valid), .item(item), .item_pop(item_pop),
        .pop(pop), .res_empty(empty), .res(res)
    );

    assign hit_valid   = res.hit_valid;
    assign hit_col     = res.hit_col;
    assign hit_row     = res.hit_row;
    assign centroid_x  = res.centroid_x;
    assign centroid_y  = res.centroid_y;
    assign centroid_ok = res.centroid_ok;

endmodule
`default_nettype wire

// ===== hdl/phh_front.sv =====
// Front end: decodes incoming items, offsets positions, and queues them.
`default_nettype none
module phh_front
    import phh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] pos_x,
    input  wire logic [15:0] pos_y,
    input  wire logic [15:0] active_width,
    input  wire logic [15:0] active_height,
    output logic             item_valid,
    output item_t            item,
    input  wire logic        item_pop
);
    localparam int FP = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    item_t        fifo_reg [FIFO_DEPTH];
    logic [FP-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [FP:0]   count_reg, count_next;
    logic signed [18:0] sum_x, sum_y;
    item_t        in_item;
    logic         do_push, do_pop;

    // offset in half units: 2*pos + active
    assign sum_x = $signed({pos_x[15], pos_x[15], pos_x, 1'b0})
                 + $signed({3'b000, active_width});
    assign sum_y = $signed({pos_y[15], pos_y[15], pos_y, 1'b0})
                 + $signed({3'b000, active_height});

    always_comb
    begin
        in_item.kind  = cmd_t'(command);
        in_item.neg_x = sum_x[18];
        in_item.neg_y = sum_y[18];
        in_item.off_x = sum_x[OFF_BITS-1:0];
        in_item.off_y = sum_y[OFF_BITS-1:0];
    end

    assign full       = (count_reg == (FP+1)'(FIFO_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = fifo_reg[head_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_pop && item_valid;

    always_comb
    begin
        head_next  = do_pop ? head_reg + 1'b1 : head_reg;
        tail_next  = do_push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg + (FP+1)'(do_push) - (FP+1)'(do_pop);
        if (FIFO_DEPTH != (1 << FP))
        begin
            if (do_pop && head_reg == FP'(FIFO_DEPTH-1))
            begin
                head_next = '0;
            end
            if (do_push && tail_reg == FP'(FIFO_DEPTH-1))
            begin
                tail_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_reg[tail_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/phh_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module phh_div #(
    parameter int N = 17,
    parameter int M = 18,
    parameter int Q = 17
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [N-1:0] dividend,
    input  wire logic [M-1:0] divisor,
    output logic              done,
    output logic [Q-1:0]      quot,
    output logic [N-1:0]      rem
);
    localparam int SW = M + Q - 1;
    localparam int W  = (N > SW) ? N : SW;
    localparam int CB = $clog2(Q + 1);

    logic [W-1:0]  rem_reg, dsh_reg;
    logic [Q-1:0]  quot_reg;
    logic [CB-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic          fits;

    assign fits = (dsh_reg <= rem_reg);
    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg[N-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CB'(Q);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CB'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= W'(dividend);
            dsh_reg  <= W'(divisor) << (Q - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quot_reg <= {quot_reg[Q-2:0], fits};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/phh_back.sv =====
// Back end: pixel mapping, histogram store, centroid sums and result register.
`default_nettype none
module phh_back
    import phh_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  item_valid,
    input  wire item_t item,
    output logic       item_pop,
    input  wire logic  pop,
    output logic       res_empty,
    output res_t       res
);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SUM_W = COUNT_BITS + AW + 5;
    localparam int PW    = COUNT_BITS + 5;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_AXIS = 8'b0000_0010,
        S_RD   = 8'b0000_0100,
        S_WR   = 8'b0000_1000,
        S_SUM  = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_CDIV = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    res_t   pend_reg, pend_next, res_reg, res_next;
    logic   res_full_reg, res_full_next;
    logic [CW-1:0] c_reg, c_next, pc_reg, pc_next;
    logic [RW-1:0] r_reg, r_next;
    logic   issue_reg, issue_next, pv_reg, pv_next;
    logic [4:0] pw_reg, pw_next;
    logic [SUM_W-1:0] tot_reg, tot_next, sx_reg, sx_next, sy_reg, sy_next;

    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]      vld_reg;
    logic [COUNT_BITS-1:0] rd_data_reg, cnt_val, wr_data;
    logic                  rd_vld_reg, rd_en, wr_en, clr;
    logic [AW-1:0]         addr;

    logic [4:0] cols, rows;
    logic [17:0] ax_div, ay_div;
    logic        start_ax, start_cd, reject;
    logic        ax_done, ay_done, cx_done, cy_done, ok_x, ok_y;
    logic [16:0] qx, qy, rx, ry, qcx, qcy;
    logic [SUM_W-1:0]    cd_x, cd_y;
    logic [PW-1:0]       px, py;

    assign cols = (5'(cfg.num_columns) > 5'(MAX_COLS)) ? 5'(MAX_COLS) : 5'(cfg.num_columns);
    assign rows = (5'(cfg.num_rows) > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : 5'(cfg.num_rows);

    // period in half units: 2*pixel, plus 2*gap in gap mode
    assign ax_div = cfg.gap_mode
        ? {(17'(cfg.pixel_width) + 17'(cfg.gap_thickness)), 1'b0}
        : {1'b0, cfg.pixel_width, 1'b0};
    assign ay_div = cfg.gap_mode
        ? {(17'(cfg.pixel_height) + 17'(cfg.gap_thickness)), 1'b0}
        : {1'b0, cfg.pixel_height, 1'b0};

    assign reject = item.neg_x || item.neg_y || (cfg.pixel_width == '0)
                 || (cfg.pixel_height == '0) || (cols == '0) || (rows == '0);

    phh_div #(.N(17), .M(18), .Q(17)) u_div_ax (
        .clk(clk), .rst_n(rst_n), .start(start_ax), .dividend(item.off_x),
        .divisor(ax_div), .done(ax_done), .quot(qx), .rem(rx)
    );
    phh_div #(.N(17), .M(18), .Q(17)) u_div_ay (
        .clk(clk), .rst_n(rst_n), .start(start_ax), .dividend(item.off_y),
        .divisor(ay_div), .done(ay_done), .quot(qy), .rem(ry)
    );

    assign cd_x = SUM_W'(tot_reg * SUM_W'(cols - 5'd1));
    assign cd_y = SUM_W'(tot_reg * SUM_W'(rows - 5'd1));

    phh_div #(.N(SUM_W + 16), .M(SUM_W), .Q(17)) u_div_cx (
        .clk(clk), .rst_n(rst_n), .start(start_cd), .dividend({sx_reg, 16'd0}),
        .divisor(cd_x), .done(cx_done), .quot(qcx), .rem()
    );
    phh_div #(.N(SUM_W + 16), .M(SUM_W), .Q(17)) u_div_cy (
        .clk(clk), .rst_n(rst_n), .start(start_cd), .dividend({sy_reg, 16'd0}),
        .divisor(cd_y), .done(cy_done), .quot(qcy), .rem()
    );

    // inside the pixel: open interval in gap mode, index below the used count
    assign ok_x = (qx < 17'(cols))
               && (!cfg.gap_mode || ((rx != '0) && (rx < {cfg.pixel_width, 1'b0})));
    assign ok_y = (qy < 17'(rows))
               && (!cfg.gap_mode || ((ry != '0) && (ry < {cfg.pixel_height, 1'b0})));

    assign addr    = AW'(AW'(c_reg) * AW'(MAX_ROWS)) + AW'(r_reg);
    assign cnt_val = rd_vld_reg ? rd_data_reg : '0;
    assign px      = PW'(cnt_val) * PW'(pc_reg);
    assign py      = PW'(cnt_val) * PW'(pw_reg);

    assign res_empty = !res_full_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        res_next      = res_reg;
        res_full_next = res_full_reg && !pop;
        c_next        = c_reg;
        r_next        = r_reg;
        pc_next       = pc_reg;
        pw_next       = pw_reg;
        issue_next    = issue_reg;
        pv_next       = 1'b0;
        tot_next      = tot_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        item_pop      = 1'b0;
        start_ax      = 1'b0;
        start_cd      = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        clr           = 1'b0;
        wr_data       = (cnt_val == COUNT_MAX) ? cnt_val : cnt_val + 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop   = 1'b1;
                    pend_next  = '0;
                    state_next = S_EMIT;
                    case (item.kind)
                        CMD_CLEAR:
                        begin
                            clr = 1'b1;
                        end
                        CMD_HIT:
                        begin
                            if (!reject)
                            begin
                                start_ax   = 1'b1;
                                state_next = S_AXIS;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (cols != '0 && rows != '0)
                            begin
                                c_next     = '0;
                                r_next     = '0;
                                issue_next = 1'b1;
                                tot_next   = '0;
                                sx_next    = '0;
                                sy_next    = '0;
                                state_next = S_SUM;
                            end
                        end
                        default:
                        begin
                            pend_next = '0;
                        end
                    endcase
                end
            end
            S_AXIS:
            begin
                if (ax_done && ay_done)
                begin
                    if (ok_x && ok_y)
                    begin
                        c_next     = qx[CW-1:0];
                        r_next     = qy[RW-1:0];
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                wr_en               = 1'b1;
                pend_next.hit_valid = 1'b1;
                pend_next.hit_col   = 3'(c_reg);
                pend_next.hit_row   = 3'(r_reg);
                state_next          = S_EMIT;
            end
            S_SUM:
            begin
                if (issue_reg)
                begin
                    rd_en   = 1'b1;
                    pv_next = 1'b1;
                    pc_next = c_reg;
                    pw_next = rows - 5'd1 - 5'(r_reg);
                    if (5'(r_reg) == rows - 5'd1)
                    begin
                        r_next = '0;
                        if (5'(c_reg) == cols - 5'd1)
                        begin
                            issue_next = 1'b0;
                        end
                        else
                        begin
                            c_next = c_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                    end
                end
                if (pv_reg)
                begin
                    tot_next = tot_reg + SUM_W'(cnt_val);
                    sx_next  = sx_reg + SUM_W'(px);
                    sy_next  = sy_reg + SUM_W'(py);
                end
                if (!issue_reg && !pv_reg)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (tot_reg != '0 && cols > 5'd1 && rows > 5'd1)
                begin
                    start_cd   = 1'b1;
                    state_next = S_CDIV;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_CDIV:
            begin
                if (cx_done && cy_done)
                begin
                    pend_next.centroid_x  = qcx;
                    pend_next.centroid_y  = qcy;
                    pend_next.centroid_ok = 1'b1;
                    state_next            = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!res_full_reg || pop)
                begin
                    res_next      = pend_reg;
                    res_full_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            res_full_reg <= 1'b0;
            issue_reg    <= 1'b0;
            pv_reg       <= 1'b0;
            vld_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            res_full_reg <= res_full_next;
            issue_reg    <= issue_next;
            pv_reg       <= pv_next;
            if (clr)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        res_reg  <= res_next;
        c_reg    <= c_next;
        r_reg    <= r_next;
        pc_reg   <= pc_next;
        pw_reg   <= pw_next;
        tot_reg  <= tot_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
            rd_vld_reg  <= vld_reg[addr];
        end
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/phh_checker.sv =====
// Port-level checks of the pixel hit histogram unit and their binding.
`default_nettype none
module phh_checker
    import phh_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     push,
    input wire logic                     full,
    input wire logic [1:0]               command,
    input wire logic [15:0]              pos_x,
    input wire logic [15:0]              pos_y,
    input wire logic                     empty,
    input wire logic                     pop,
    input wire logic                     hit_valid,
    input wire logic [2:0]               hit_col,
    input wire logic [2:0]               hit_row,
    input wire logic [16:0]              centroid_x,
    input wire logic [16:0]              centroid_y,
    input wire logic                     centroid_ok,
    input wire logic                     cfg_valid,
    input wire logic                     cfg_ready,
    input wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input wire logic [CFG_DATA_BITS-1:0] cfg_data
);
    // a waiting result holds until its transfer
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(hit_valid) && $stable(hit_col)
            && $stable(hit_row) && $stable(centroid_x) && $stable(centroid_y)
            && $stable(centroid_ok)))
        else $error("result changed before transfer");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(hit_valid && centroid_ok))
        else $error("hit and centroid flagged together");

    a_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !hit_valid) |-> (hit_col == 3'd0 && hit_row == 3'd0))
        else $error("pixel index without a counted hit");

    a_cent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !centroid_ok) |-> (centroid_x == 17'd0 && centroid_y == 17'd0))
        else $error("centroid value without a valid centroid");

endmodule

bind pixel_hit_histogram_centroid_unit phh_checker u_phh_checker (.*);
`default_nettype wire

// ===== tb/hit_histogram_checker.sv =====
// Checker for the pixel hit histogram unit: predicts each result and compares it.
module hit_histogram_checker
    import phh_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire logic                     full,
    input  wire logic [1:0]               command,
    input  wire logic [15:0]              pos_x,
    input  wire logic [15:0]              pos_y,
    input  wire logic                     empty,
    input  wire logic                     pop,
    input  wire logic                     hit_valid,
    input  wire logic [2:0]               hit_col,
    input  wire logic [2:0]               hit_row,
    input  wire logic [16:0]              centroid_x,
    input  wire logic [16:0]              centroid_y,
    input  wire logic                     centroid_ok,
    input  wire logic                     cfg_valid,
    input  wire logic                     cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                            failures,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOLS = DEF_MAX_COLS;
    localparam int NROWS = DEF_MAX_ROWS;
    localparam logic [DEF_COUNT_BITS-1:0] COUNT_FULL = '1;

    cfg_t                      shadow_cfg;
    logic [DEF_COUNT_BITS-1:0] pixel_counts [NCOLS*NROWS];
    res_t                      expected_results [$];

    function automatic int clip(input logic [3:0] v, input int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    // Map one axis to a pixel index, in half units so no rounding is needed.
    function automatic bit locate_pixel(input logic [15:0] pos, input logic [15:0] active,
                                        input logic [15:0] pix, input int n,
                                        output int idx);
        longint            off2;
        longint unsigned   d, per, i, r;
        off2 = 2 * longint'($signed(pos)) + longint'(active);
        idx = 0;
        if (off2 < 0 || pix == 0 || n == 0)
            return 0;
        d = longint'(off2);
        if (shadow_cfg.gap_mode) begin
            per = 2 * (longint'(pix) + longint'(shadow_cfg.gap_thickness));
            i = d / per;
            r = d - i * per;
            if (r == 0 || r >= 2 * longint'(pix))
                return 0;
        end
        else begin
            i = d / (2 * longint'(pix));
        end
        if (i >= n)
            return 0;
        idx = int'(i);
        return 1;
    endfunction

    // Apply one command to the shadow histogram and return the result it yields.
    function automatic res_t histogram_step(input cmd_t cmd, input logic [15:0] x,
                                            input logic [15:0] y);
        res_t              res;
        int                cols, rows, c, r;
        longint unsigned   tot, sx, sy, n;
        res = '0;
        cols = clip(shadow_cfg.num_columns, NCOLS);
        rows = clip(shadow_cfg.num_rows, NROWS);
        case (cmd)
            CMD_CLEAR: begin
                foreach (pixel_counts[k])
                    pixel_counts[k] = '0;
            end
            CMD_HIT: begin
                if (locate_pixel(x, shadow_cfg.active_width, shadow_cfg.pixel_width, cols, c)
                    && locate_pixel(y, shadow_cfg.active_height, shadow_cfg.pixel_height,
                                    rows, r)) begin
                    if (pixel_counts[c*NROWS+r] != COUNT_FULL)
                        pixel_counts[c*NROWS+r] += 1'b1;
                    res.hit_valid = 1'b1;
                    res.hit_col = c[2:0];
                    res.hit_row = r[2:0];
                end
            end
            CMD_QUERY: begin
                tot = 0;
                sx = 0;
                sy = 0;
                for (int ci = 0; ci < cols; ci++) begin
                    for (int ri = 0; ri < rows; ri++) begin
                        n = pixel_counts[ci*NROWS+ri];
                        tot += n;
                        sx += ci * n;
                        sy += (rows - 1 - ri) * n;
                    end
                end
                if (tot != 0 && cols > 1 && rows > 1) begin
                    res.centroid_x = 17'(((sx << 16) / ((cols - 1) * tot)));
                    res.centroid_y = 17'(((sy << 16) / ((rows - 1) * tot)));
                    res.centroid_ok = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic cfg_t reset_cfg();
        cfg_t c;
        c.num_columns = 4'd8;
        c.num_rows = 4'd8;
        c.gap_mode = 1'b0;
        c.active_width = 16'd3200;
        c.active_height = 16'd3200;
        c.pixel_width = 16'd400;
        c.pixel_height = 16'd400;
        c.gap_thickness = 16'd0;
        return c;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        res_t got, want;
        if (!rst_n) begin
            shadow_cfg <= reset_cfg();
            foreach (pixel_counts[k])
                pixel_counts[k] = '0;
            expected_results.delete();
            failures <= 0;
            pending <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NUM_COLUMNS:   shadow_cfg.num_columns <= cfg_data[3:0];
                    REG_NUM_ROWS:      shadow_cfg.num_rows <= cfg_data[3:0];
                    REG_GAP_MODE:      shadow_cfg.gap_mode <= cfg_data[0];
                    REG_ACTIVE_WIDTH:  shadow_cfg.active_width <= cfg_data;
                    REG_ACTIVE_HEIGHT: shadow_cfg.active_height <= cfg_data;
                    REG_PIXEL_WIDTH:   shadow_cfg.pixel_width <= cfg_data;
                    REG_PIXEL_HEIGHT:  shadow_cfg.pixel_height <= cfg_data;
                    REG_GAP_THICKNESS: shadow_cfg.gap_thickness <= cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                got = {hit_valid, hit_col, hit_row, centroid_x, centroid_y, centroid_ok};
                if (expected_results.size() == 0) begin
                    if (failures < 10)
                        $display("%0t: result with nothing expected: %p", $time, got);
                    failures <= failures + 1;
                end
                else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (failures < 10)
                            $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        failures <= failures + 1;
                    end
                end
            end
            if (push && !full)
                expected_results.insert(expected_results.size(),
                                        histogram_step(cmd_t'(command), pos_x, pos_y));
            pending <= expected_results.size();
        end
    end
endmodule

// ===== tb/testbench.sv =====
// Top of the testbench: stimulus, idling, watchdog and verdict for the hit histogram unit.
module testbench
    import phh_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 150;
    localparam int PHASES         = 10;
    localparam int ITEMS_PER_PHASE = 145;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic [1:0]               command = CMD_NONE;
    logic [15:0]              pos_x = '0;
    logic [15:0]              pos_y = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic                     hit_valid;
    logic [2:0]               hit_col, hit_row;
    logic [16:0]              centroid_x, centroid_y;
    logic                     centroid_ok;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    int                       failures, pending;

    // Idle rates in percent for each side, and a long hold-off of the receiver.
    int send_idle = 12;
    int recv_idle = 77;
    bit recv_hold = 1'b0;
    int quiet_cycles = 0;
    cfg_t cur_cfg;

    always #4 clk = ~clk;

    pixel_hit_histogram_centroid_unit u_top (.*);

    hit_histogram_checker u_checker (.*);

    // Receiver: pop at random, never during a hold-off.
    always @(posedge clk)
        pop <= rst_n && !recv_hold && ($urandom_range(99) >= recv_idle);

    // Watchdog: count cycles in which no transfer happens on any channel.
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("pixel_hit_histogram_centroid_unit verification failed");
            $finish;
        end
    end

    // Offer one item; hold push until the transfer. Push stays high for the next item.
    task automatic offer_item(input cmd_t cmd, input logic [15:0] x, input logic [15:0] y);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        command <= cmd;
        pos_x <= x;
        pos_y <= y;
        do @(posedge clk); while (full);
    endtask

    // Let every expected result drain, then wait out the back end.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_cfg(input cfg_t c);
        write_reg(REG_NUM_COLUMNS, {12'd0, c.num_columns});
        write_reg(REG_NUM_ROWS, {12'd0, c.num_rows});
        write_reg(REG_GAP_MODE, {15'd0, c.gap_mode});
        write_reg(REG_ACTIVE_WIDTH, c.active_width);
        write_reg(REG_ACTIVE_HEIGHT, c.active_height);
        write_reg(REG_PIXEL_WIDTH, c.pixel_width);
        write_reg(REG_PIXEL_HEIGHT, c.pixel_height);
        write_reg(REG_GAP_THICKNESS, c.gap_thickness);
        cur_cfg = c;
    endtask

    function automatic cfg_t make_cfg(input int cols, input int rows, input bit gap,
                                      input int aw, input int ah, input int pw,
                                      input int ph, input int gt);
        cfg_t c;
        c.num_columns = 4'(cols);
        c.num_rows = 4'(rows);
        c.gap_mode = gap;
        c.active_width = 16'(aw);
        c.active_height = 16'(ah);
        c.pixel_width = 16'(pw);
        c.pixel_height = 16'(ph);
        c.gap_thickness = 16'(gt);
        return c;
    endfunction

    // Mostly a detector that fits its pixels; now and then a wild or extreme one.
    function automatic cfg_t random_cfg(input int ph);
        int cols, rows, pw, phh, gt;
        bit gap;
        if (ph % 4 == 3)
            return make_cfg($urandom_range(15), $urandom_range(15), $urandom_range(1),
                            $urandom_range(65535), $urandom_range(65535),
                            $urandom_range(65535), $urandom_range(65535),
                            $urandom_range(65535));
        cols = $urandom_range(1, 8);
        rows = $urandom_range(1, 8);
        gap = ph % 2;
        pw = $urandom_range(1, 2000);
        phh = $urandom_range(1, 2000);
        gt = gap ? $urandom_range(0, 300) : $urandom_range(65535);
        return make_cfg(cols, rows, gap, cols * (pw + (gap ? gt : 0)),
                        rows * (phh + (gap ? gt : 0)), pw, phh, gt);
    endfunction

    // Positions near the active area, with stray and edge values mixed in.
    function automatic logic [15:0] random_pos(input logic [15:0] active,
                                               input logic [15:0] pix);
        int half, p;
        half = int'(active) / 2;
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'(-half + int'(pix) * $urandom_range(8));
            default: begin
                p = -half + int'($urandom_range(int'(active) + 40)) - 20;
                if (p > 32767) p = 32767;
                if (p < -32768) p = -32768;
                return 16'(p);
            end
        endcase
    endfunction

    task automatic random_item();
        int pick;
        cmd_t cmd;
        pick = $urandom_range(99);
        cmd = (pick < 84) ? CMD_HIT : (pick < 93) ? CMD_QUERY : (pick < 97) ? CMD_CLEAR
                                                                            : CMD_NONE;
        offer_item(cmd, random_pos(cur_cfg.active_width, cur_cfg.pixel_width),
                   random_pos(cur_cfg.active_height, cur_cfg.pixel_height));
    endtask

    initial begin
        cur_cfg = make_cfg(8, 8, 0, 3200, 3200, 400, 400, 0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, field extremes, every command, edges of the area.
        offer_item(CMD_QUERY, 16'd0, 16'd0);
        offer_item(CMD_HIT, 16'd0, 16'd0);
        offer_item(CMD_HIT, -16'sd1600, -16'sd1600);
        offer_item(CMD_HIT, 16'd1599, 16'd1599);
        offer_item(CMD_HIT, 16'd1600, 16'd0);
        offer_item(CMD_HIT, -16'sd1601, 16'd0);
        offer_item(CMD_HIT, 16'h8000, 16'h7fff);
        offer_item(CMD_HIT, 16'h7fff, 16'h8000);
        offer_item(CMD_NONE, 16'hffff, 16'hffff);
        offer_item(CMD_QUERY, 16'hffff, 16'h0000);
        offer_item(CMD_CLEAR, 16'h0000, 16'hffff);
        offer_item(CMD_QUERY, 16'd0, 16'd0);
        drain();

        // Gap mode: hits on a pixel edge and inside a gap are rejected.
        load_cfg(make_cfg(15, 15, 1, 3400, 3400, 400, 400, 25));
        offer_item(CMD_HIT, -16'sd1700, 16'd0);
        offer_item(CMD_HIT, -16'sd1300, 16'd0);
        offer_item(CMD_HIT, -16'sd1290, 16'd0);
        offer_item(CMD_HIT, -16'sd1699, -16'sd1699);
        offer_item(CMD_QUERY, 16'd0, 16'd0);
        drain();

        // Zero pixel size, zero columns and a single column.
        load_cfg(make_cfg(0, 8, 0, 3200, 3200, 0, 400, 0));
        offer_item(CMD_HIT, 16'd0, 16'd0);
        offer_item(CMD_QUERY, 16'd0, 16'd0);
        drain();
        load_cfg(make_cfg(1, 8, 0, 65535, 65535, 65535, 1, 65535));
        offer_item(CMD_HIT, 16'd0, 16'd0);
        offer_item(CMD_HIT, 16'd100, -16'sd200);
        offer_item(CMD_QUERY, 16'd0, 16'd0);
        drain();

        // Random phases across settings and idle patterns.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES / 3) begin
                send_idle = 77;
                recv_idle = 12;
            end
            else if (ph == 2 * PHASES / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            load_cfg(random_cfg(ph));
            if (ph == 1) begin
                // Hold the receiver off while items keep coming, to fill the queues.
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (400) @(posedge clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                random_item();
            offer_item(CMD_QUERY, 16'd0, 16'd0);
            drain();
        end

        if (failures == 0 && pending == 0)
            $display("pixel_hit_histogram_centroid_unit verification clean");
        else
            $display("pixel_hit_histogram_centroid_unit verification failed");
        $finish;
    end
endmodule
